/* src/aip_pkg.sv */
// Package for the ASCII integer parser: widths, phase, character and radix codes, digit decode.
package aip_pkg;

  localparam int unsigned MaxCharsDefault = 4096;
  localparam int unsigned ConsumedW       = 13;
  localparam int unsigned ValueW          = 64;
  localparam int unsigned RadixW          = 6;
  localparam int unsigned CharW           = 8;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhWs     = 3'd1,
    PhPrefix = 3'd2,
    PhZero   = 3'd3,
    PhDigits = 3'd4
  } phase_e;

  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0d;
  localparam logic [CharW-1:0] ChPlus  = 8'h2b;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowZ  = 8'h7a;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5a;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;

  localparam logic [RadixW-1:0] RadixAuto = 6'd0;
  localparam logic [RadixW-1:0] RadixOct  = 6'd8;
  localparam logic [RadixW-1:0] RadixDec  = 6'd10;
  localparam logic [RadixW-1:0] RadixHex  = 6'd16;

  typedef struct packed {
    logic              ok;
    logic [RadixW-1:0] val;
  } digit_t;

  function automatic logic is_ws(input logic [CharW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic digit_t digit_of(input logic [CharW-1:0] c);
    digit_t d;
    logic [CharW-1:0] t;
    d = '0;
    t = '0;
    if ((c >= ChZero) && (c <= ChNine)) begin
      t = c - ChZero;
      d.ok = 1'b1;
    end else if ((c >= ChLowA) && (c <= ChLowZ)) begin
      t = c - ChLowA + 8'd10;
      d.ok = 1'b1;
    end else if ((c >= ChUpA) && (c <= ChUpZ)) begin
      t = c - ChUpA + 8'd10;
      d.ok = 1'b1;
    end
    d.val = t[RadixW-1:0];
    return d;
  endfunction

endpackage

/* src/ascii_integer_parser_unit.sv */
// Streaming ASCII-to-integer parser, one character per item.
// Pipeline: an accepted item is registered in the input stage, then processed into the
//   parser state and the output register once the output register is free.
// Throughput: one item per cycle while the output is not stalled; the single 64x6
//   multiply-add on the accumulator lies on the parser-state feedback path.
// Reset: asynchronous, active low; clears the pipeline valids and the parser state.
module ascii_integer_parser_unit
  import aip_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MaxCharsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CharW-1:0]     ch_i,
  input  logic                 first_i,
  input  logic [RadixW-1:0]    radix_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ValueW-1:0]    value_o,
  output logic [ConsumedW-1:0] consumed_o
);

  localparam int unsigned CntW = $clog2(MAX_CHARS + 1);

  logic                 s1_valid_q;
  logic [CharW-1:0]     ch_q;
  logic                 first_q;
  logic [RadixW-1:0]    radix_in_q;

  phase_e               phase_q, phase_d;
  logic [ValueW-1:0]    accum_q, accum_d;
  logic [RadixW-1:0]    radix_q, radix_d;
  logic                 minus_q, minus_d;
  logic [CntW-1:0]      count_q, count_d;

  logic                 out_valid_q;
  logic [ValueW-1:0]    value_q;
  logic [ConsumedW-1:0] consumed_q;

  logic                 out_free;
  logic                 in_accept;
  logic                 proc;
  logic                 emit;
  logic                 take;
  logic                 done;
  digit_t               dig;
  logic [ValueW-1:0]    product;
  logic [ValueW-1:0]    result_value;
  logic [CntW+ConsumedW-1:0] count_ext;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign proc       = s1_valid_q && out_free;
  assign dig        = digit_of(ch_q);

  always_comb begin
    phase_d = phase_q;
    accum_d = accum_q;
    radix_d = radix_q;
    minus_d = minus_q;
    count_d = count_q;
    emit    = 1'b0;
    take    = 1'b0;
    done    = 1'b0;
    product = '0;
    if (first_q) begin
      phase_d = PhWs;
      accum_d = '0;
      radix_d = radix_in_q;
      minus_d = 1'b0;
      count_d = '0;
    end
    if (phase_d == PhIdle) begin
      done = 1'b1;
    end
    if (!done && (phase_d == PhWs)) begin
      if (is_ws(ch_q)) begin
        take = 1'b1;
        done = 1'b1;
      end else begin
        phase_d = (radix_d == RadixAuto) ? PhPrefix : PhDigits;
        if ((ch_q == ChPlus) || (ch_q == ChMinus)) begin
          minus_d = (ch_q == ChMinus);
          take    = 1'b1;
          done    = 1'b1;
        end
      end
    end
    if (!done && (phase_d == PhPrefix)) begin
      if (ch_q == ChZero) begin
        take    = 1'b1;
        phase_d = PhZero;
        done    = 1'b1;
      end else begin
        radix_d = RadixDec;
        phase_d = PhDigits;
      end
    end
    if (!done && (phase_d == PhZero)) begin
      if ((ch_q == ChLowX) || (ch_q == ChUpX)) begin
        take    = 1'b1;
        radix_d = RadixHex;
        phase_d = PhDigits;
        done    = 1'b1;
      end else begin
        radix_d = RadixOct;
        phase_d = PhDigits;
      end
    end
    if (!done && (phase_d == PhDigits)) begin
      if (dig.ok && (dig.val < radix_d)) begin
        product = accum_d * ValueW'(radix_d);
        accum_d = product + ValueW'(dig.val);
        take    = 1'b1;
      end else begin
        emit    = 1'b1;
        phase_d = PhIdle;
      end
    end
    if (take && (count_d < CntW'(MAX_CHARS))) begin
      count_d = count_d + CntW'(1);
    end
  end

  assign result_value = minus_d ? (ValueW'(0) - accum_d) : accum_d;
  assign count_ext    = {{ConsumedW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || out_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q       <= ch_i;
      first_q    <= first_i;
      radix_in_q <= radix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      accum_q <= '0;
      radix_q <= '0;
      minus_q <= 1'b0;
      count_q <= '0;
    end else if (proc) begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      radix_q <= radix_d;
      minus_q <= minus_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && proc && emit) begin
      value_q    <= result_value;
      consumed_q <= count_ext[ConsumedW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign consumed_o  = consumed_q;

endmodule

/* src/aip_checker.sv */
// Port-level checker for the ASCII integer parser and its bind to the top level.
module aip_checker
  import aip_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MaxCharsDefault
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [ValueW-1:0]    value_o,
  input logic [ConsumedW-1:0] consumed_o
);

  localparam int unsigned BoundW = 18;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(value_o) && $stable(consumed_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a preceding item");

  a_consumed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (BoundW'(consumed_o) <= BoundW'(MAX_CHARS)))
    else $error("consumed count above limit");

endmodule

bind ascii_integer_parser_unit aip_checker #(
  .MAX_CHARS(MAX_CHARS)
) u_aip_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .value_o    (value_o),
  .consumed_o (consumed_o)
);
